>>> src/sign_random_projection_hash_unit_macros.svh
// Assertion macros for the sign random projection hash unit.
// Used by the top level; expects clk and arst_n in scope.
`ifndef SIGN_RANDOM_PROJECTION_HASH_UNIT_MACROS_SVH
`define SIGN_RANDOM_PROJECTION_HASH_UNIT_MACROS_SVH

// Implication checked every cycle outside reset.
`define SRPH_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication checked on the cycle after the antecedent.
`define SRPH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/srph_pkg.sv
// Shared types and constants for the sign random projection hash unit.
// No dependencies.
package srph_pkg;

	localparam int BITS_PER_BYTE = 8;
	localparam int CFG_IDX_W     = 1;
	localparam int CFG_DATA_W    = 9;
	localparam int ELEM_W        = 16;
	localparam int PROD_W        = 2 * ELEM_W;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_ELEM = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_VECTOR_LENGTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BYTE_COUNT    = 1'd1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ACC,
		ST_DRAIN,
		ST_EMIT,
		ST_SETTLE,
		ST_OUT
	} srph_state_t;

endpackage

>>> src/srph_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module srph_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

>>> src/srph_mac.sv
// Multiply-accumulate stages: registered product, then sum update write-back.
// Depends on srph_pkg.
module srph_mac #(
	parameter int SUM_W = 40,
	parameter int P_W   = 6
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             v_s2,
	input  logic [P_W-1:0]                   p_s2,
	input  logic signed [srph_pkg::ELEM_W-1:0] element,
	input  logic signed [srph_pkg::ELEM_W-1:0] weight,
	input  logic signed [SUM_W-1:0]          sum_rd,
	output logic                             wr_en,
	output logic [P_W-1:0]                   wr_addr,
	output logic signed [SUM_W-1:0]          wr_data
);

	logic                                v_s3;
	logic [P_W-1:0]                      p_s3;
	logic signed [srph_pkg::PROD_W-1:0] prod_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		p_s3    <= p_s2;
		prod_s3 <= element * weight;
	end

	assign wr_en   = v_s3;
	assign wr_addr = p_s3;
	assign wr_data = sum_rd + SUM_W'(prod_s3);

endmodule

>>> src/sign_random_projection_hash_unit.sv
// Element: accepted in idle, then MAC issue for 8*byte_count projections, then a drain.
// Vector end adds an emit sweep over 8*MAX_HASH_BYTES sums, then one byte per cycle while out_ready is high.
// Loads are taken in idle. One shared MAC reading weight and sum memories sets the rate.
// After reset a clearing pass zeroes all 8*MAX_HASH_BYTES sums; no word
// is accepted meanwhile. Registers reset to length 256 and 8 bytes.
`include "sign_random_projection_hash_unit_macros.svh"
module sign_random_projection_hash_unit #(
	parameter int MAX_DIMENSION  = 256,
	parameter int MAX_HASH_BYTES = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                command,
	input  logic [13:0]                         weight_address,
	input  logic signed [15:0]                  weight_value,
	input  logic signed [15:0]                  element_value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [2:0]                          byte_index,
	output logic [7:0]                          hash_byte,
	output logic                                last_byte,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [srph_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [srph_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int PROJ   = MAX_HASH_BYTES * srph_pkg::BITS_PER_BYTE;
	localparam int WDEPTH = PROJ * MAX_DIMENSION;
	localparam int WA_W   = $clog2(WDEPTH);
	localparam int P_W    = $clog2(PROJ);
	localparam int POS_W  = $clog2(MAX_DIMENSION);
	localparam int LEN_W  = $clog2(MAX_DIMENSION + 1);
	localparam int NB_W   = $clog2(MAX_HASH_BYTES + 1);
	localparam int SUM_W  = 32 + $clog2(MAX_DIMENSION);

	srph_pkg::srph_state_t state_q, state_d;

	logic [8:0]        vector_length_q;
	logic [3:0]        byte_count_q;
	logic [POS_W-1:0]  pos_q;
	logic              vec_end_q;
	logic [P_W-1:0]    plast_q;
	logic [NB_W-1:0]   nb_q;
	logic [P_W-1:0]    p_q;
	logic [WA_W-1:0]   waddr_q;
	logic              v_s2;
	logic [P_W-1:0]    p_s2;
	logic              emit_v_q;
	logic [PROJ-1:0]   hash_q;
	logic [NB_W-1:0]   b_q;
	logic              out_valid_q;
	logic [2:0]        byte_index_q;
	logic [7:0]        hash_byte_q;
	logic              last_byte_q;
	logic signed [15:0] elem_q;

	logic [LEN_W-1:0]  len_eff;
	logic [NB_W-1:0]   nb_eff;
	logic              acc_go;
	logic              load_go;
	logic              out_load;
	logic              out_last;
	logic [31:0]       waddr_ext;

	logic                    w_wr_en;
	logic signed [15:0]      w_rd;
	logic                    s_wr_en;
	logic [P_W-1:0]          s_wr_addr;
	logic signed [SUM_W-1:0] s_wr_data;
	logic [P_W-1:0]          s_rd_addr;
	logic signed [SUM_W-1:0] s_rd;
	logic                    mac_wr_en;
	logic [P_W-1:0]          mac_wr_addr;
	logic signed [SUM_W-1:0] mac_wr_data;

	always_comb begin
		if (vector_length_q == 9'd0) begin
			len_eff = LEN_W'(1);
		end else if (32'(vector_length_q) > MAX_DIMENSION) begin
			len_eff = LEN_W'(MAX_DIMENSION);
		end else begin
			len_eff = LEN_W'(vector_length_q);
		end
		if (byte_count_q == 4'd0) begin
			nb_eff = NB_W'(1);
		end else if (32'(byte_count_q) > MAX_HASH_BYTES) begin
			nb_eff = NB_W'(MAX_HASH_BYTES);
		end else begin
			nb_eff = NB_W'(byte_count_q);
		end
	end

	assign in_ready  = (state_q == srph_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign acc_go    = in_valid && in_ready && (command == srph_pkg::CMD_ELEM);
	assign load_go   = in_valid && in_ready && (command == srph_pkg::CMD_LOAD);
	assign waddr_ext = 32'(weight_address);
	assign w_wr_en   = load_go && (waddr_ext < WDEPTH);
	assign out_load  = (state_q == srph_pkg::ST_OUT) && (!out_valid_q || out_ready);
	assign out_last  = (b_q + NB_W'(1)) == nb_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			srph_pkg::ST_CLEAR: begin
				if (p_q == P_W'(PROJ - 1)) state_d = srph_pkg::ST_IDLE;
			end
			srph_pkg::ST_IDLE: begin
				if (acc_go) state_d = srph_pkg::ST_ACC;
			end
			srph_pkg::ST_ACC: begin
				if (p_q == plast_q) state_d = srph_pkg::ST_DRAIN;
			end
			srph_pkg::ST_DRAIN: begin
				if (!v_s2 && !mac_wr_en) begin
					state_d = vec_end_q ? srph_pkg::ST_EMIT : srph_pkg::ST_IDLE;
				end
			end
			srph_pkg::ST_EMIT: begin
				if (p_q == P_W'(PROJ - 1)) state_d = srph_pkg::ST_SETTLE;
			end
			srph_pkg::ST_SETTLE: begin
				state_d = srph_pkg::ST_OUT;
			end
			srph_pkg::ST_OUT: begin
				if (out_load && out_last) state_d = srph_pkg::ST_IDLE;
			end
			default: state_d = srph_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srph_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vector_length_q <= 9'd256;
			byte_count_q    <= 4'd8;
			pos_q           <= '0;
			p_q             <= '0;
			v_s2            <= 1'b0;
			emit_v_q        <= 1'b0;
			b_q             <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					srph_pkg::REG_VECTOR_LENGTH: vector_length_q <= cfg_data;
					srph_pkg::REG_BYTE_COUNT:    byte_count_q    <= cfg_data[3:0];
				endcase
			end
			if (acc_go) begin
				if (32'(pos_q) + 32'd1 >= 32'(len_eff)) begin
					pos_q <= '0;
				end else begin
					pos_q <= pos_q + POS_W'(1);
				end
			end
			if (state_q == srph_pkg::ST_CLEAR || state_q == srph_pkg::ST_ACC ||
				state_q == srph_pkg::ST_EMIT) begin
				p_q <= (state_d == state_q) ? p_q + P_W'(1) : '0;
			end
			v_s2     <= (state_q == srph_pkg::ST_ACC);
			emit_v_q <= (state_q == srph_pkg::ST_EMIT);
			if (state_q == srph_pkg::ST_SETTLE) begin
				b_q <= '0;
			end else if (out_load) begin
				b_q <= b_q + NB_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath words
	always_ff @(posedge clk) begin
		p_s2 <= p_q;
		if (acc_go) begin
			elem_q    <= element_value;
			waddr_q   <= WA_W'(pos_q);
			vec_end_q <= (32'(pos_q) + 32'd1 >= 32'(len_eff));
			plast_q   <= P_W'(32'(nb_eff) * srph_pkg::BITS_PER_BYTE - 1);
			nb_q      <= nb_eff;
		end else if (state_q == srph_pkg::ST_ACC) begin
			waddr_q <= waddr_q + WA_W'(MAX_DIMENSION);
		end
		if (emit_v_q) begin
			hash_q <= {hash_q[PROJ-2:0], (!s_rd[SUM_W-1] && (s_rd != '0))};
		end else if (out_load) begin
			hash_q <= hash_q << srph_pkg::BITS_PER_BYTE;
		end
		if (out_load) begin
			hash_byte_q  <= hash_q[PROJ-1 -: 8];
			byte_index_q <= 3'(b_q);
			last_byte_q  <= out_last;
		end
	end

	srph_ram #(.WIDTH(16), .DEPTH(WDEPTH)) u_weight_ram (
		.clk     (clk),
		.wr_en   (w_wr_en),
		.wr_addr (waddr_ext[WA_W-1:0]),
		.wr_data (weight_value),
		.rd_addr (waddr_q),
		.rd_data (w_rd)
	);

	always_comb begin
		if (state_q == srph_pkg::ST_CLEAR || state_q == srph_pkg::ST_EMIT) begin
			s_wr_en   = 1'b1;
			s_wr_addr = p_q;
			s_wr_data = '0;
		end else begin
			s_wr_en   = mac_wr_en;
			s_wr_addr = mac_wr_addr;
			s_wr_data = mac_wr_data;
		end
		s_rd_addr = (state_q == srph_pkg::ST_EMIT) ? p_q : p_s2;
	end

	srph_ram #(.WIDTH(SUM_W), .DEPTH(PROJ)) u_sum_ram (
		.clk     (clk),
		.wr_en   (s_wr_en),
		.wr_addr (s_wr_addr),
		.wr_data (s_wr_data),
		.rd_addr (s_rd_addr),
		.rd_data (s_rd)
	);

	srph_mac #(.SUM_W(SUM_W), .P_W(P_W)) u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.v_s2    (v_s2),
		.p_s2    (p_s2),
		.element (elem_q),
		.weight  (w_rd),
		.sum_rd  (s_rd),
		.wr_en   (mac_wr_en),
		.wr_addr (mac_wr_addr),
		.wr_data (mac_wr_data)
	);

	assign out_valid  = out_valid_q;
	assign byte_index = byte_index_q;
	assign hash_byte  = hash_byte_q;
	assign last_byte  = last_byte_q;

	`SRPH_ASSERT(a_no_sum_overlap, v_s2 && mac_wr_en, p_s2 != mac_wr_addr, "sum RMW overlap")
	`SRPH_ASSERT(a_idle_drained, in_ready, !v_s2 && !mac_wr_en, "word accepted while MAC busy")
	`SRPH_ASSERT(a_pos_range, 1'b1, 32'(pos_q) < MAX_DIMENSION, "element position out of range")
	`SRPH_ASSERT_NEXT(a_emit_start, state_q == srph_pkg::ST_DRAIN && state_d == srph_pkg::ST_EMIT,
		p_q == '0, "emit sweep not starting at first sum")

endmodule
